@@ sv/pilot_tone_locator_defines.svh @@
// Assertion macros for the pilot tone locator checker.
// Needs clk_i and rst_ni in the scope where the macros are used.
`ifndef PILOT_TONE_LOCATOR_DEFINES_SVH
`define PILOT_TONE_LOCATOR_DEFINES_SVH

// The condition in one cycle implies the consequence in the next.
`define PTL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pilot_tone_locator: next-cycle check failed");

// The condition holds at every clock edge out of reset.
`define PTL_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("pilot_tone_locator: invariant check failed");

`endif

@@ sv/ptl_pkg.sv @@
// Shared types and constants for the pilot tone locator.
// No dependencies; imported by every module of the block.
package ptl_pkg;

  localparam int PILOT_PERIOD = 100;
  localparam int INDEX_BITS   = 20;
  localparam int SAMPLE_W     = 16;
  localparam int SUM_W        = 24;
  localparam int DELTA_W      = 19;
  localparam int PROD_W       = 2 * SUM_W;
  localparam int LENGTH_W     = 20;
  localparam int OFFSET_W     = 20;
  localparam int NUM_CORR     = 4;
  localparam int QUEUE_DEPTH  = 4;
  localparam int CMP_W        = (INDEX_BITS + 1 > LENGTH_W) ? INDEX_BITS + 1 : LENGTH_W;

  localparam logic [LENGTH_W-1:0] LENGTH_RESET = LENGTH_W'(441000);

  // History keeps PILOT_PERIOD-1 older samples; the newest comes from the queue.
  // Tap h[k] (k >= 1, after the push) is history entry k-1.
  localparam int HIST_DEPTH = PILOT_PERIOD - 1;
  localparam int TAP_HALF   = PILOT_PERIOD / 2;
  localparam int TAP_QTR    = PILOT_PERIOD / 4;
  localparam int TAP_3QTR   = (3 * PILOT_PERIOD) / 4;
  localparam int H_LAST     = PILOT_PERIOD - 2;
  localparam int H_HALF_A   = TAP_HALF - 2;
  localparam int H_HALF_B   = TAP_HALF - 1;
  localparam int H_QTR_A    = TAP_QTR - 2;
  localparam int H_QTR_B    = TAP_QTR - 1;
  localparam int H_3QTR_A   = TAP_3QTR - 2;
  localparam int H_3QTR_B   = TAP_3QTR - 1;

  typedef enum logic [0:0] {
    REG_SWAP   = 1'b0,
    REG_LENGTH = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    PK_IDLE,
    PK_MUL1,
    PK_CMP1,
    PK_MUL2,
    PK_CMP2,
    PK_OUT
  } pick_state_e;

  typedef logic [INDEX_BITS-1:0] index_t;
  typedef logic [1:0]            chan_t;

  typedef struct packed {
    logic [15:0] left_word;
    logic [15:0] right_word;
  } in_item_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] pilot_offset;
    logic [1:0]          pilot_channel;
  } out_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } sample_pair_t;

  // Extremes of all four correlators at the end of a search.
  typedef struct packed {
    logic [NUM_CORR-1:0][SUM_W-1:0] largest;
    logic [NUM_CORR-1:0][SUM_W-1:0] smallest;
    index_t [NUM_CORR-1:0]          largest_where;
    index_t [NUM_CORR-1:0]          smallest_where;
  } snap_t;

endpackage

@@ sv/pilot_tone_locator.sv @@
// Top level of the pilot tone locator: APB register file, front queue,
// correlator core and result picker. Depends on ptl_pkg and the ptl_* modules.
//
//   channel   signals                              direction  payload
//   in        in_valid_i / in_ready_o              sink       in_item_t (left/right word)
//   out       out_valid_o / out_ready_i            source     out_item_t (offset, channel)
//   cfg       psel/penable/pwrite/paddr/pwdata...  APB slave  swap_bytes, search_length
//
// Cycles: one sample pair per cycle sustained; a transaction reaches the
//   correlators through the queue write, the tap stage and the update.
// End of search: the picker scans with two 24x24 multipliers shared over four
//   correlators; channel 0 always settles at the first compare, the others at
//   the first or second, and the result then sits in the output register.
// Stalls: the last sample of a search waits while the picker is still busy
//   with the previous search, so searches shorter than about 16 samples slow
//   intake; the 4-entry queue absorbs short hiccups on either side.
// Reset: asynchronous, active low; all correlator and history state clears at
//   once, swap_bytes comes up as 1 and search_length as 441000.
module pilot_tone_locator (
  input  logic               clk_i,
  input  logic               rst_ni,
  // sample transactions
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ptl_pkg::in_item_t  in_item_i,
  // result transactions
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ptl_pkg::out_item_t out_item_o,
  // configuration
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [2:0]         paddr_i,
  input  logic [31:0]        pwdata_i,
  output logic [31:0]        prdata_o,
  output logic               pready_o
);
  import ptl_pkg::*;

  logic                swap_q;
  logic [LENGTH_W-1:0] length_q;
  logic                cfg_wr;
  reg_idx_e            reg_idx;

  logic                q_valid, q_pop;
  sample_pair_t        q_data;
  logic                snap_valid, pick_ready;
  snap_t               snap;

  // register index is the word address
  assign reg_idx  = reg_idx_e'(paddr_i[2]);
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i && pready_o;

  always_comb begin
    unique case (reg_idx)
      REG_SWAP:   prdata_o = {31'b0, swap_q};
      REG_LENGTH: prdata_o = {{(32 - LENGTH_W){1'b0}}, length_q};
      default:    prdata_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swap_q   <= 1'b1;
      length_q <= LENGTH_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_SWAP:   swap_q   <= pwdata_i[0];
        REG_LENGTH: length_q <= pwdata_i[LENGTH_W-1:0];
        default:    ;
      endcase
    end
  end

  // front: accept, swap, sign, queue
  ptl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .swap_i     (swap_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .q_valid_o  (q_valid),
    .q_data_o   (q_data),
    .q_pop_i    (q_pop)
  );

  // back: delay lines, correlators, extreme tracking
  ptl_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .length_i     (length_q),
    .q_valid_i    (q_valid),
    .q_data_i     (q_data),
    .q_pop_o      (q_pop),
    .pick_ready_i (pick_ready),
    .snap_valid_o (snap_valid),
    .snap_o       (snap)
  );

  // ratio scan and output register
  ptl_pick u_pick (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_valid_i (snap_valid),
    .snap_i       (snap),
    .ready_o      (pick_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item_o)
  );

endmodule

@@ sv/ptl_front.sv @@
// Front end: accepts sample transactions, byte-swaps and signs them,
// and queues them for the core. Depends on ptl_pkg.
module ptl_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  swap_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ptl_pkg::in_item_t     in_item_i,
  output logic                  q_valid_o,
  output ptl_pkg::sample_pair_t q_data_o,
  input  logic                  q_pop_i
);
  import ptl_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  sample_pair_t       mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               push, pop;
  sample_pair_t       entry;

  function automatic logic signed [SAMPLE_W-1:0] to_sample(logic sw, logic [15:0] w);
    return sw ? $signed({w[7:0], w[15:8]}) : $signed(w);
  endfunction

  assign in_ready_o = (count_q != CNT_W'(QUEUE_DEPTH));
  assign q_valid_o  = (count_q != '0);
  assign q_data_o   = mem_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && q_valid_o;

  assign entry.left  = to_sample(swap_i, in_item_i.left_word);
  assign entry.right = to_sample(swap_i, in_item_i.right_word);

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= entry;
    end
  end

endmodule

@@ sv/ptl_core.sv @@
// Back end: delay lines, tap deltas, the four correlators and the
// crossing-triggered extreme trackers. Depends on ptl_pkg.
module ptl_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [ptl_pkg::LENGTH_W-1:0] length_i,
  input  logic                         q_valid_i,
  input  ptl_pkg::sample_pair_t        q_data_i,
  output logic                         q_pop_o,
  input  logic                         pick_ready_i,
  output logic                         snap_valid_o,
  output ptl_pkg::snap_t               snap_o
);
  import ptl_pkg::*;

  // stage A: history and deltas
  logic signed [SAMPLE_W-1:0] hist_q [2][HIST_DEPTH];
  logic signed [SAMPLE_W-1:0] smp [2];
  index_t                     idx_q;
  logic                       a_valid_q, a_last_q;
  index_t                     a_idx_q;
  logic signed [DELTA_W-1:0]  dlt_q [NUM_CORR];
  logic signed [DELTA_W-1:0]  dlt_d [NUM_CORR];
  logic [LENGTH_W-1:0]        limit;
  logic                       last;

  // stage B: correlator state
  logic signed [SUM_W-1:0] sum_q [NUM_CORR];
  logic signed [SUM_W-1:0] lg_q  [NUM_CORR];
  logic signed [SUM_W-1:0] sm_q  [NUM_CORR];
  index_t                  lgw_q [NUM_CORR];
  index_t                  smw_q [NUM_CORR];
  logic signed [SUM_W-1:0] sum_new [NUM_CORR];
  logic signed [SUM_W-1:0] lg_new  [NUM_CORR];
  logic signed [SUM_W-1:0] sm_new  [NUM_CORR];
  index_t                  lgw_new [NUM_CORR];
  index_t                  smw_new [NUM_CORR];
  logic [NUM_CORR-1:0]     crossed;
  logic                    b_stall, b_fire;

  function automatic logic signed [DELTA_W-1:0] ext(logic signed [SAMPLE_W-1:0] v);
    return DELTA_W'(v);
  endfunction

  assign smp[0] = q_data_i.left;
  assign smp[1] = q_data_i.right;

  // zero search length behaves as one
  assign limit = (length_i == '0) ? LENGTH_W'(1) : length_i;
  assign last  = (CMP_W'(idx_q) + CMP_W'(1)) >= CMP_W'(limit);

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      dlt_d[2*c]   = ext(smp[c]) - ext(hist_q[c][H_HALF_A]) - ext(hist_q[c][H_HALF_B])
                   + ext(hist_q[c][H_LAST]);
      dlt_d[2*c+1] = ext(smp[c]) - ext(hist_q[c][H_QTR_A]) - ext(hist_q[c][H_QTR_B])
                   + ext(hist_q[c][H_3QTR_A]) + ext(hist_q[c][H_3QTR_B])
                   - ext(hist_q[c][H_LAST]);
    end
  end

  // the last sample of a search waits in stage A until the picker is free
  assign b_stall      = a_valid_q && a_last_q && !pick_ready_i;
  assign b_fire       = a_valid_q && !b_stall;
  assign q_pop_o      = q_valid_i && !b_stall;
  assign snap_valid_o = a_valid_q && a_last_q && pick_ready_i;

  always_comb begin
    for (int k = 0; k < NUM_CORR; k++) begin
      sum_new[k] = sum_q[k] + SUM_W'(dlt_q[k]);
      crossed[k] = sum_q[k][SUM_W-1] ^ sum_new[k][SUM_W-1];
    end
    // a crossing on one member of a pair samples its partner
    for (int k = 0; k < NUM_CORR; k++) begin
      lg_new[k]  = lg_q[k];
      lgw_new[k] = lgw_q[k];
      sm_new[k]  = sm_q[k];
      smw_new[k] = smw_q[k];
      if (crossed[k ^ 1] && (sum_new[k] > lg_q[k])) begin
        lg_new[k]  = sum_new[k];
        lgw_new[k] = a_idx_q;
      end
      if (crossed[k ^ 1] && (sum_new[k] < sm_q[k])) begin
        sm_new[k]  = sum_new[k];
        smw_new[k] = a_idx_q;
      end
      snap_o.largest[k]        = lg_new[k];
      snap_o.smallest[k]       = sm_new[k];
      snap_o.largest_where[k]  = lgw_new[k];
      snap_o.smallest_where[k] = smw_new[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      a_valid_q <= 1'b0;
      a_last_q  <= 1'b0;
      a_idx_q   <= '0;
      for (int c = 0; c < 2; c++) begin
        for (int j = 0; j < HIST_DEPTH; j++) begin
          hist_q[c][j] <= '0;
        end
      end
      for (int k = 0; k < NUM_CORR; k++) begin
        dlt_q[k] <= '0;
        sum_q[k] <= '0;
        lg_q[k]  <= SUM_W'(1);
        sm_q[k]  <= '1;
        lgw_q[k] <= '0;
        smw_q[k] <= '0;
      end
    end else begin
      if (!b_stall) begin
        a_valid_q <= q_pop_o;
        if (q_pop_o) begin
          a_last_q <= last;
          a_idx_q  <= idx_q;
          idx_q    <= last ? '0 : idx_q + 1'b1;
          for (int k = 0; k < NUM_CORR; k++) begin
            dlt_q[k] <= dlt_d[k];
          end
          for (int c = 0; c < 2; c++) begin
            if (last) begin
              for (int j = 0; j < HIST_DEPTH; j++) begin
                hist_q[c][j] <= '0;
              end
            end else begin
              for (int j = HIST_DEPTH - 1; j > 0; j--) begin
                hist_q[c][j] <= hist_q[c][j-1];
              end
              hist_q[c][0] <= smp[c];
            end
          end
        end
      end
      if (b_fire) begin
        for (int k = 0; k < NUM_CORR; k++) begin
          if (a_last_q) begin
            sum_q[k] <= '0;
            lg_q[k]  <= SUM_W'(1);
            sm_q[k]  <= '1;
            lgw_q[k] <= '0;
            smw_q[k] <= '0;
          end else begin
            sum_q[k] <= sum_new[k];
            lg_q[k]  <= lg_new[k];
            sm_q[k]  <= sm_new[k];
            lgw_q[k] <= lgw_new[k];
            smw_q[k] <= smw_new[k];
          end
        end
      end
    end
  end

endmodule

@@ sv/ptl_pick.sv @@
// Result picker: scans the four correlators, compares ratios by cross
// products on two shared multipliers, holds the result. Depends on ptl_pkg.
module ptl_pick (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               snap_valid_i,
  input  ptl_pkg::snap_t     snap_i,
  output logic               ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ptl_pkg::out_item_t out_item_o
);
  import ptl_pkg::*;

  pick_state_e state_q, state_d;

  // largest is always >= 1 and smallest <= -1, so magnitudes are never zero
  logic [SUM_W-1:0]  hi_q [NUM_CORR];
  logic [SUM_W-1:0]  lo_q [NUM_CORR];
  index_t            hiw_q [NUM_CORR];
  index_t            low_q [NUM_CORR];
  chan_t             ch_q;
  logic [SUM_W-1:0]  bnum_q, bden_q;
  index_t            boff_q;
  chan_t             bch_q;
  logic [PROD_W-1:0] pa_q, pb_q;
  logic              out_valid_q;
  out_item_t         out_item_q;

  logic              load, do_mul, mul_lo, take, take_lo, adv, out_load;
  logic [SUM_W-1:0]  hi_sel, lo_sel, num_sel, den_sel;
  logic [PROD_W-1:0] pa_d, pb_d;
  index_t            off_sel;

  assign hi_sel  = hi_q[ch_q];
  assign lo_sel  = lo_q[ch_q];
  assign take_lo = (state_q == PK_CMP2);
  assign num_sel = take_lo ? lo_sel : hi_sel;
  assign den_sel = take_lo ? hi_sel : lo_sel;
  assign off_sel = take_lo ? low_q[ch_q] : hiw_q[ch_q];
  assign pa_d    = (mul_lo ? lo_sel : hi_sel) * bden_q;
  assign pb_d    = bnum_q * (mul_lo ? hi_sel : lo_sel);

  assign ready_o     = (state_q == PK_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_comb begin
    state_d  = state_q;
    load     = 1'b0;
    do_mul   = 1'b0;
    mul_lo   = 1'b0;
    take     = 1'b0;
    adv      = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      PK_IDLE: begin
        if (snap_valid_i) begin
          load    = 1'b1;
          state_d = PK_MUL1;
        end
      end
      PK_MUL1: begin
        do_mul  = 1'b1;
        state_d = PK_CMP1;
      end
      PK_CMP1: begin
        if (pa_q > pb_q) begin
          take = 1'b1;
          adv  = 1'b1;
        end else begin
          state_d = PK_MUL2;
        end
      end
      PK_MUL2: begin
        do_mul  = 1'b1;
        mul_lo  = 1'b1;
        state_d = PK_CMP2;
      end
      PK_CMP2: begin
        take = (pa_q > pb_q);
        adv  = 1'b1;
      end
      PK_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = PK_IDLE;
        end
      end
      default: state_d = PK_IDLE;
    endcase
    if (adv) begin
      state_d = (ch_q == chan_t'(NUM_CORR - 1)) ? PK_OUT : PK_MUL1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= PK_IDLE;
      out_valid_q <= 1'b0;
      ch_q        <= '0;
    end else begin
      state_q <= state_d;
      if (load) begin
        ch_q <= '0;
      end else if (adv) begin
        ch_q <= ch_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int k = 0; k < NUM_CORR; k++) begin
        hi_q[k]  <= snap_i.largest[k];
        lo_q[k]  <= ~snap_i.smallest[k] + 1'b1;
        hiw_q[k] <= snap_i.largest_where[k];
        low_q[k] <= snap_i.smallest_where[k];
      end
      bnum_q <= '0;
      bden_q <= SUM_W'(1);
      boff_q <= '0;
      bch_q  <= '0;
    end else if (take) begin
      bnum_q <= num_sel;
      bden_q <= den_sel;
      boff_q <= off_sel;
      bch_q  <= ch_q;
    end
    if (do_mul) begin
      pa_q <= pa_d;
      pb_q <= pb_d;
    end
    if (out_load) begin
      out_item_q.pilot_offset  <= OFFSET_W'(boff_q);
      out_item_q.pilot_channel <= bch_q;
    end
  end

endmodule

@@ sv/ptl_checker.sv @@
// Port-level checks for the pilot tone locator, bound to the top level.
// Depends on ptl_pkg and pilot_tone_locator_defines.svh.
`include "pilot_tone_locator_defines.svh"

module ptl_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input ptl_pkg::out_item_t out_item_o,
  input logic               psel_i,
  input logic               penable_i,
  input logic               pwrite_i,
  input logic [2:0]         paddr_i,
  input logic [31:0]        pwdata_i,
  input logic [31:0]        prdata_o,
  input logic               pready_o
);

  // a held result transaction keeps its payload
  `PTL_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_item_o))

  // register writes read back on the next cycle
  `PTL_ASSERT_NEXT(a_swap_readback, psel_i && penable_i && pwrite_i && !paddr_i[2], paddr_i[2] || prdata_o[0] == $past(pwdata_i[0]))
  `PTL_ASSERT_NEXT(a_length_readback, psel_i && penable_i && pwrite_i && paddr_i[2], !paddr_i[2] || prdata_o[19:0] == $past(pwdata_i[19:0]))

  // the register port never inserts wait states
  `PTL_ASSERT_ALWAYS(a_pready_high, pready_o)

endmodule

bind pilot_tone_locator ptl_checker u_ptl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o),
  .psel_i      (psel_i),
  .penable_i   (penable_i),
  .pwrite_i    (pwrite_i),
  .paddr_i     (paddr_i),
  .pwdata_i    (pwdata_i),
  .prdata_o    (prdata_o),
  .pready_o    (pready_o)
);

@@ tb/pilot_tone_locator_tb.sv @@
// Self-checking bench for pilot_tone_locator: sample transactions, APB register
// writes with read-back, and a built-in predictor of every pilot location.
// Depends on ptl_pkg and the pilot_tone_locator RTL; reads no files.
module pilot_tone_locator_tb;
  import ptl_pkg::*;

  // Covers the pipeline and the worst picker time, with margin. Used before any
  // register write and at the end of the run.
  localparam int SETTLE_CYCLES = 40;
  // Longest run of cycles without a transaction before the run is abandoned.
  // The long output hold below is the worst legitimate case.
  localparam int STALL_LIMIT   = 5000;
  localparam int LONG_HOLD     = 400;
  localparam int RANDOM_ITEMS  = 650;
  localparam int MAX_SHOWN     = 10;

  typedef enum logic [0:0] {ROW_SAMPLE, ROW_WRITE} row_kind_e;
  typedef enum logic [1:0] {PH_PILOT, PH_NOISE, PH_DETUNED} phase_flavor_e;

  // One sample transaction; directed rows may carry the location it must give.
  typedef struct packed {
    in_item_t  item;
    logic      fixed;
    out_item_t want;
  } sample_job_t;

  typedef struct {
    row_kind_e   kind;
    reg_idx_e    regsel;
    logic [31:0] value;
    sample_job_t job;
  } row_t;

  // ---------------------------------------------------------------------------
  // DUT hookup. Every input has a known value from time zero.
  // ---------------------------------------------------------------------------
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_item_t    in_item_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_item_o;
  logic        psel_i      = 1'b0;
  logic        penable_i   = 1'b0;
  logic        pwrite_i    = 1'b0;
  logic [2:0]  paddr_i     = '0;
  logic [31:0] pwdata_i    = '0;
  logic [31:0] prdata_o;
  logic        pready_o;

  pilot_tone_locator uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .psel_i      (psel_i),
    .penable_i   (penable_i),
    .pwrite_i    (pwrite_i),
    .paddr_i     (paddr_i),
    .pwdata_i    (pwdata_i),
    .prdata_o    (prdata_o),
    .pready_o    (pready_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Bench bookkeeping
  // ---------------------------------------------------------------------------
  sample_job_t job_fifo[$];          // generated, not yet on the bus
  sample_job_t offered_job = '0;     // the job currently driven on in_item_i
  out_item_t   awaited_locations[$]; // predicted results, oldest first
  bit          rst_done;
  bit          idling_on = 1'b1;
  bit          hold_req;
  int          send_gap, recv_stall, hold_left;
  int          jobs_pushed, samples_taken, locations_seen;
  int          mismatches, quiet_cycles, writes_done, holds_done;

  // ---------------------------------------------------------------------------
  // Predictor: register mirror plus a private copy of the search state
  // ---------------------------------------------------------------------------
  bit                  mirror_swap;
  logic [LENGTH_W-1:0] mirror_length;
  int                  left_taps [PILOT_PERIOD];  // [0] is the newest sample
  int                  right_taps[PILOT_PERIOD];
  int                  corr   [NUM_CORR];         // 0 left I, 1 left Q, 2 right I, 3 right Q
  int                  peak_hi[NUM_CORR];
  int                  peak_lo[NUM_CORR];
  index_t              peak_hi_at[NUM_CORR];
  index_t              peak_lo_at[NUM_CORR];
  index_t              pair_count;

  function automatic void clear_search();
    for (int k = 0; k < PILOT_PERIOD; k++) begin
      left_taps[k]  = 0;
      right_taps[k] = 0;
    end
    for (int k = 0; k < NUM_CORR; k++) begin
      corr[k]       = 0;
      peak_hi[k]    = 1;
      peak_lo[k]    = -1;
      peak_hi_at[k] = '0;
      peak_lo_at[k] = '0;
    end
    pair_count = '0;
  endfunction

  function automatic int to_signed_sample(logic [15:0] word);
    logic [15:0] w;
    w = mirror_swap ? {word[7:0], word[15:8]} : word;
    return int'($signed(w));
  endfunction

  function automatic int wrap_sum(int v);
    logic signed [SUM_W-1:0] t;
    t = v[SUM_W-1:0];
    return int'(t);
  endfunction

  // Sign change on correlator k samples its partner (k ^ 1).
  function automatic void sample_extremes(int k, index_t at);
    if (corr[k] > peak_hi[k]) begin
      peak_hi[k]    = corr[k];
      peak_hi_at[k] = at;
    end
    if (corr[k] < peak_lo[k]) begin
      peak_lo[k]    = corr[k];
      peak_lo_at[k] = at;
    end
  endfunction

  // Advance the search by one sample pair; returns 1 when a location is due.
  function automatic bit locate_pilot(in_item_t item, output out_item_t found);
    int     prior[NUM_CORR];
    int     delta [NUM_CORR];
    int     limit;
    longint hi, lo, best_num, best_den;
    index_t at;
    at    = pair_count;
    found = '0;
    for (int k = PILOT_PERIOD - 1; k > 0; k--) begin
      left_taps[k]  = left_taps[k-1];
      right_taps[k] = right_taps[k-1];
    end
    left_taps[0]  = to_signed_sample(item.left_word);
    right_taps[0] = to_signed_sample(item.right_word);

    // square-wave correlators: I flips sign at half period, Q at the quarters
    delta[0] = left_taps[0] - left_taps[TAP_HALF-1] - left_taps[TAP_HALF]
             + left_taps[PILOT_PERIOD-1];
    delta[1] = left_taps[0] - left_taps[TAP_QTR-1] - left_taps[TAP_QTR]
             + left_taps[TAP_3QTR-1] + left_taps[TAP_3QTR] - left_taps[PILOT_PERIOD-1];
    delta[2] = right_taps[0] - right_taps[TAP_HALF-1] - right_taps[TAP_HALF]
             + right_taps[PILOT_PERIOD-1];
    delta[3] = right_taps[0] - right_taps[TAP_QTR-1] - right_taps[TAP_QTR]
             + right_taps[TAP_3QTR-1] + right_taps[TAP_3QTR] - right_taps[PILOT_PERIOD-1];
    for (int k = 0; k < NUM_CORR; k++) begin
      prior[k] = corr[k];
      corr[k]  = wrap_sum(prior[k] + delta[k]);
    end
    for (int k = 0; k < NUM_CORR; k++) begin
      if ((prior[k] < 0) != (corr[k] < 0)) sample_extremes(k ^ 1, at);
    end

    // a zero length behaves as one; a lowered length ends the search at once
    limit = (mirror_length == '0) ? 1 : int'(mirror_length);
    if (int'(pair_count) + 1 < limit) begin
      pair_count = pair_count + 1'b1;
      return 1'b0;
    end

    // best ratio, strictly greater wins, compared by cross-multiplication
    best_num = 0;
    best_den = 1;
    for (int k = 0; k < NUM_CORR; k++) begin
      hi = (peak_hi[k] < 0) ? -longint'(peak_hi[k]) : longint'(peak_hi[k]);
      lo = (peak_lo[k] < 0) ? -longint'(peak_lo[k]) : longint'(peak_lo[k]);
      if (hi == 0 || lo == 0) continue;
      if (hi * best_den > best_num * lo) begin
        best_num            = hi;
        best_den            = lo;
        found.pilot_offset  = peak_hi_at[k];
        found.pilot_channel = chan_t'(k);
      end else if (lo * best_den > best_num * hi) begin
        best_num            = lo;
        best_den            = hi;
        found.pilot_offset  = peak_lo_at[k];
        found.pilot_channel = chan_t'(k);
      end
    end
    clear_search();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: offers jobs from job_fifo, with random gap bursts between them.
  // Valid is never withdrawn before the transaction completes.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : sender
    sample_job_t next_job;
    if (rst_done && (!in_valid_i || in_ready_o)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (job_fifo.size() > 0) begin
        next_job    = job_fifo.pop_front();
        offered_job <= next_job;
        in_item_i   <= next_job.item;
        in_valid_i  <= 1'b1;
        if (idling_on && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 14);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, plus a long hold on request so the block
  // backs up into its input.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_done) begin
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (idling_on && $urandom_range(0, 6) == 0) recv_stall = $urandom_range(1, 14);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on accepted samples, checks accepted locations.
  // ---------------------------------------------------------------------------
  task automatic log_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_SHOWN) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  always @(posedge clk_i) begin : monitor
    out_item_t predicted;
    out_item_t want;
    bit        due;
    if (rst_done) begin
      quiet_cycles++;
      if (out_valid_o && out_ready_i) begin
        quiet_cycles = 0;
        locations_seen++;
        if (awaited_locations.size() == 0) begin
          log_mismatch($sformatf("location offset=%0d channel=%0d with none awaited",
                                 out_item_o.pilot_offset, out_item_o.pilot_channel));
        end else begin
          want = awaited_locations.pop_front();
          if (out_item_o.pilot_offset !== want.pilot_offset)
            log_mismatch($sformatf("pilot_offset expected %0d got %0d",
                                   want.pilot_offset, out_item_o.pilot_offset));
          if (out_item_o.pilot_channel !== want.pilot_channel)
            log_mismatch($sformatf("pilot_channel expected %0d got %0d",
                                   want.pilot_channel, out_item_o.pilot_channel));
        end
      end
      if (in_valid_i && in_ready_o) begin
        quiet_cycles = 0;
        due = locate_pilot(in_item_i, predicted);
        // a typed-in row stands for itself; the predictor still tracks state
        if (offered_job.fixed) awaited_locations.push_back(offered_job.want);
        else if (due) awaited_locations.push_back(predicted);
        samples_taken++;
      end
    end
  end

  // Watchdog: no transaction on either side for too long.
  always @(posedge clk_i) begin
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[%0t] no transaction for %0d cycles, %0d locations still awaited",
               $realtime, quiet_cycles, awaited_locations.size());
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Wait until every sample has gone in and every location has come out, then
  // let the pipeline drain samples that produce nothing.
  task automatic settle();
    while (samples_taken != jobs_pushed || awaited_locations.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_cycle(reg_idx_e r, bit wr, logic [31:0] v, output logic [31:0] rd);
    @(posedge clk_i);
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= wr;
    paddr_i   <= {r, 2'b00};
    pwdata_i  <= v;
    @(posedge clk_i);
    penable_i <= 1'b1;
    do @(posedge clk_i); while (!pready_o);
    rd = prdata_o;
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
  endtask

  // Register writes only happen with the block idle; each is read back.
  task automatic set_register(reg_idx_e r, logic [31:0] v);
    logic [31:0] back;
    logic [31:0] mask;
    settle();
    apb_cycle(r, 1'b1, v, back);
    apb_cycle(r, 1'b0, '0, back);
    mask = (r == REG_SWAP) ? 32'h1 : 32'h000F_FFFF;
    if (back !== (v & mask))
      log_mismatch($sformatf("register %s read back %0h, wrote %0h", r.name(), back, v));
    if (r == REG_SWAP) mirror_swap = v[0];
    else mirror_length = v[LENGTH_W-1:0];
    writes_done++;
  endtask

  task automatic offer(logic [15:0] l, logic [15:0] r);
    sample_job_t j;
    j                 = '0;
    j.item.left_word  = l;
    j.item.right_word = r;
    job_fifo.push_back(j);
    jobs_pushed++;
  endtask

  // Clamp to 16 bits and store in the byte order the block is set up for.
  function automatic logic [15:0] encode_word(int s);
    logic [15:0] w;
    if (s > 32767) s = 32767;
    else if (s < -32768) s = -32768;
    w = 16'(s);
    return mirror_swap ? {w[7:0], w[15:8]} : w;
  endfunction

  // Pilot: square wave at the pilot period plus noise. Detuned: same at a
  // random period 20..180, maybe the pilot's. Noise: raw random words.
  task automatic feed_phase(int count, phase_flavor_e flavor);
    int period, amp_l, amp_r, ph_l, ph_r, spread, s_l, s_r;
    period = (flavor == PH_DETUNED) ? $urandom_range(20, 180) : PILOT_PERIOD;
    amp_l  = $urandom_range(50, 30000);
    amp_r  = $urandom_range(50, 30000);
    ph_l   = $urandom_range(0, period - 1);
    ph_r   = $urandom_range(0, period - 1);
    spread = $urandom_range(0, 4000);
    for (int n = 0; n < count; n++) begin
      if (flavor == PH_NOISE) begin
        offer(16'($urandom), 16'($urandom));
      end else begin
        s_l = (((n + ph_l) % period) < period / 2) ? amp_l : -amp_l;
        s_r = (((n + ph_r) % period) < period / 2) ? amp_r : -amp_r;
        s_l += int'($urandom_range(0, 2 * spread)) - spread;
        s_r += int'($urandom_range(0, 2 * spread)) - spread;
        offer(encode_word(s_l), encode_word(s_r));
      end
    end
  endtask

  function automatic row_t sample_row(logic [15:0] l, logic [15:0] r, bit fixed = 1'b0,
                                      index_t off = '0, chan_t ch = '0);
    row_t row;
    row.kind                     = ROW_SAMPLE;
    row.regsel                   = REG_SWAP;
    row.value                    = '0;
    row.job.item.left_word       = l;
    row.job.item.right_word      = r;
    row.job.fixed                = fixed;
    row.job.want.pilot_offset    = off;
    row.job.want.pilot_channel   = ch;
    return row;
  endfunction

  function automatic row_t write_row(reg_idx_e r, logic [31:0] v);
    row_t row;
    row.kind   = ROW_WRITE;
    row.regsel = r;
    row.value  = v;
    row.job    = '0;
    return row;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    row_t          rows[$];
    phase_flavor_e flavor;
    int            span, burst, pick, phases, random_fed;

    clear_search();
    mirror_swap   = 1'b1;
    mirror_length = LENGTH_RESET;

    repeat (12) @(posedge clk_i);
    rst_ni   <= 1'b1;
    rst_done = 1'b1;

    // Directed rows. Search length one makes every sample end a search, so
    // the location of a single sample after a clear can be read off directly:
    // offset is always 0, and a lone full-scale negative sample on one side
    // wins on that side's quadrature (left) or in-phase (right) correlator.
    // Swap is still at its reset value for the first rows.
    rows.push_back(write_row(REG_LENGTH, 1));
    rows.push_back(sample_row(16'h0000, 16'h0000, 1'b1, '0, 2'd0));
    rows.push_back(sample_row(16'h0080, 16'h0000, 1'b1, '0, 2'd1));
    rows.push_back(sample_row(16'h0000, 16'h0080, 1'b1, '0, 2'd2));
    rows.push_back(sample_row(16'hFFFF, 16'hFFFF));
    rows.push_back(sample_row(16'hFF7F, 16'hFF7F));
    // little-endian words
    rows.push_back(write_row(REG_SWAP, 0));
    rows.push_back(sample_row(16'h8000, 16'h0000, 1'b1, '0, 2'd1));
    rows.push_back(sample_row(16'h7FFF, 16'h8000));
    // zero length is taken as one
    rows.push_back(write_row(REG_LENGTH, 0));
    rows.push_back(sample_row(16'h1234, 16'hEDCB));
    rows.push_back(sample_row(16'h8001, 16'h0001));
    // short search over a full-scale step, channels in opposite phase
    rows.push_back(write_row(REG_LENGTH, 10));
    for (int n = 0; n < 10; n++)
      rows.push_back(n < 5 ? sample_row(16'h7FFF, 16'h8000) : sample_row(16'h8000, 16'h7FFF));
    // longest search, cut short by lowering the length mid-search
    rows.push_back(write_row(REG_LENGTH, 32'h000F_FFFF));
    rows.push_back(sample_row(16'h4000, 16'hC000));
    rows.push_back(sample_row(16'hC000, 16'h4000));
    rows.push_back(sample_row(16'h0001, 16'hFFFE));
    rows.push_back(write_row(REG_LENGTH, 2));
    rows.push_back(sample_row(16'h0100, 16'hFF00));
    rows.push_back(write_row(REG_SWAP, 1));

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_WRITE) begin
        set_register(rows[i].regsel, rows[i].value);
      end else begin
        job_fifo.push_back(rows[i].job);
        jobs_pushed++;
      end
    end

    // Random phases: each picks byte order, search length and signal flavor.
    // Short searches give many results; long ones exercise deep correlation.
    random_fed = 0;
    phases     = 0;
    while (random_fed < RANDOM_ITEMS && phases < 200) begin
      phases++;
      idling_on = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 1) == 1) set_register(REG_SWAP, $urandom_range(0, 1));
      if (phases == 2 || $urandom_range(0, 14) == 0) begin
        // back-pressure: every sample or every second sample ends a search while the output is held
        set_register(REG_LENGTH, $urandom_range(1, 2));
        hold_req = 1'b1;
        feed_phase(60, PH_NOISE);
        random_fed += 60;
        continue;
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) span = $urandom_range(0, 3);
      else if (pick < 4) span = $urandom_range(4, 20);
      else if (pick < 8) span = $urandom_range(21, 150);
      else span = $urandom_range(151, 400);
      set_register(REG_LENGTH, span);
      burst = (span <= 20) ? $urandom_range(20, 120)
                           : span * $urandom_range(1, 2) + $urandom_range(0, 30);
      pick   = $urandom_range(0, 9);
      flavor = (pick < 7) ? PH_PILOT : (pick < 9) ? PH_NOISE : PH_DETUNED;
      feed_phase(burst, flavor);
      random_fed += burst;
    end

    // Closing stretch at full rate on both sides.
    idling_on = 1'b0;
    set_register(REG_LENGTH, $urandom_range(5, 30));
    feed_phase(150, PH_PILOT);
    settle();

    $display("Run covered %0d sample pairs over %0d register writes and %0d long output holds;",
             samples_taken, writes_done, holds_done);
    $display("%0d pilot locations checked, %0d mismatches.", locations_seen, mismatches);
    if (mismatches == 0 && awaited_locations.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/ptl_pkg.sv
sv/ptl_front.sv
sv/ptl_core.sv
sv/ptl_pick.sv
sv/pilot_tone_locator.sv
sv/ptl_checker.sv
tb/pilot_tone_locator_tb.sv
